// ===== hw/rtl/sdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcd_pkg: serial display command decoder package
// Character codes, target codes and digit helpers for the decoder.
// ----------------------------------------------------------------------------
package sdcd_pkg;

    // Default brightness ceiling
    localparam int BRIGHT_MAX_DEFAULT = 100;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int TARGET_W = 3;
    localparam int VALUE_W  = 24;
    localparam int SLOT_W   = 3;

    // Command and digit characters
    localparam logic [BYTE_W-1:0] CH_MODE_BRIGHT = 8'h62; // 'b'
    localparam logic [BYTE_W-1:0] CH_MODE_COLOUR = 8'h63; // 'c'
    localparam logic [BYTE_W-1:0] CH_ZERO        = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CH_NINE        = 8'h39; // '9'
    localparam logic [BYTE_W-1:0] CH_ROW_LAST    = 8'h35; // '5'
    localparam logic [BYTE_W-1:0] CH_UPPER_A     = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CH_UPPER_F     = 8'h46; // 'F'
    localparam logic [BYTE_W-1:0] CH_LOWER_A     = 8'h61; // 'a'
    localparam logic [BYTE_W-1:0] CH_LOWER_F     = 8'h66; // 'f'

    // Result targets
    localparam logic [TARGET_W-1:0] TGT_BRIGHT = 3'd0;
    localparam logic [SLOT_W-1:0]   SLOT_NONE  = 3'd0;
    localparam logic [SLOT_W-1:0]   SLOT_LAST  = 3'd6;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = 8'h00;
        if (b inside {[CH_ZERO:CH_NINE]})
        begin
            d = b - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        else if (b inside {[CH_UPPER_A:CH_UPPER_F]})
        begin
            d = b - CH_UPPER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        else if (b inside {[CH_LOWER_A:CH_LOWER_F]})
        begin
            d = b - CH_LOWER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// ===== hw/rtl/serial_display_command_decoder.sv =====
// ----------------------------------------------------------------------------
// serial_display_command_decoder
// Decodes brightness ('b') and colour ('c') commands from a byte stream.
// ----------------------------------------------------------------------------
// A result appears on out_valid in the cycle after the closing byte is taken.
// Throughput: one byte per cycle while in_ready is high; decode is a single registered pass.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n low, asynchronous): waiting for a mode byte, accumulators
// cleared, no colour slot selected, result register empty.
module serial_display_command_decoder
#(
    parameter int BRIGHT_MAX = sdcd_pkg::BRIGHT_MAX_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sdcd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            burst_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sdcd_pkg::TARGET_W-1:0]   target,
    output logic [sdcd_pkg::VALUE_W-1:0]    value
);
    import sdcd_pkg::*;

    localparam int ACC_W = $clog2(BRIGHT_MAX + 1);
    localparam int MUL_W = ACC_W + 4;
    localparam logic [MUL_W-1:0] BRIGHT_CAP = MUL_W'(BRIGHT_MAX);

    typedef enum logic [1:0]
    {
        PH_MODE,
        PH_DEC,
        PH_ROW,
        PH_HEX
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [ACC_W-1:0]     dec_acc_reg, dec_acc_next;
    logic [VALUE_W-1:0]   hex_acc_reg, hex_acc_next;
    logic                 res_valid_reg, res_valid_next;
    logic [TARGET_W-1:0]  res_target_reg, res_target_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;

    logic                 in_xfer;
    logic                 emit;
    logic [4:0]           hex_dig;
    logic [MUL_W-1:0]     dec_sum;
    logic [BYTE_W-1:0]    dig_ofs;

    // Take a byte whenever the result register is free or draining
    assign in_ready = !res_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign hex_dig = hex_decode(rx_byte);
    assign dig_ofs = rx_byte - CH_ZERO;
    assign dec_sum = MUL_W'(dec_acc_reg) * MUL_W'(10) + MUL_W'(dig_ofs[3:0]);

    // Command decode
    always_comb
    begin
        phase_next      = phase_reg;
        slot_next       = slot_reg;
        dec_acc_next    = dec_acc_reg;
        hex_acc_next    = hex_acc_reg;
        emit            = 1'b0;
        res_target_next = res_target_reg;
        res_value_next  = res_value_reg;
        case (phase_reg)
            PH_MODE:
            begin
                if (rx_byte == CH_MODE_BRIGHT)
                begin
                    dec_acc_next = '0;
                    if (burst_end)
                    begin
                        emit            = 1'b1;
                        res_target_next = TGT_BRIGHT;
                        res_value_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_DEC;
                    end
                end
                else if (rx_byte == CH_MODE_COLOUR && !burst_end)
                begin
                    phase_next = PH_ROW;
                end
            end
            PH_DEC:
            begin
                if (rx_byte inside {[CH_ZERO:CH_NINE]})
                begin
                    dec_acc_next = (dec_sum > BRIGHT_CAP) ? ACC_W'(BRIGHT_MAX)
                                                          : dec_sum[ACC_W-1:0];
                end
                if (burst_end)
                begin
                    emit            = 1'b1;
                    res_target_next = TGT_BRIGHT;
                    res_value_next  = VALUE_W'(dec_acc_next);
                    phase_next      = PH_MODE;
                end
            end
            PH_ROW:
            begin
                slot_next    = (rx_byte inside {[CH_ZERO:CH_ROW_LAST]})
                               ? SLOT_W'(dig_ofs[2:0] + 3'd1) : SLOT_NONE;
                hex_acc_next = '0;
                if (burst_end)
                begin
                    emit            = (slot_next != SLOT_NONE);
                    res_target_next = slot_next;
                    res_value_next  = '0;
                    phase_next      = PH_MODE;
                end
                else
                begin
                    phase_next = PH_HEX;
                end
            end
            PH_HEX:
            begin
                if (hex_dig[4])
                begin
                    hex_acc_next = {hex_acc_reg[VALUE_W-5:0], hex_dig[3:0]};
                end
                if (burst_end)
                begin
                    emit            = (slot_reg != SLOT_NONE);
                    res_target_next = slot_reg;
                    res_value_next  = hex_acc_next;
                    phase_next      = PH_MODE;
                end
            end
            default:
            begin
                phase_next = PH_MODE;
            end
        endcase
    end

    // Result register valid: set by a producing byte, cleared on transfer out
    assign res_valid_next = (in_xfer && emit) ? 1'b1
                          : (out_ready ? 1'b0 : res_valid_reg);

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MODE;
            slot_reg       <= SLOT_NONE;
            dec_acc_reg    <= '0;
            hex_acc_reg    <= '0;
            res_valid_reg  <= 1'b0;
            res_target_reg <= '0;
            res_value_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (in_xfer)
            begin
                phase_reg   <= phase_next;
                slot_reg    <= slot_next;
                dec_acc_reg <= dec_acc_next;
                hex_acc_reg <= hex_acc_next;
                if (emit)
                begin
                    res_target_reg <= res_target_next;
                    res_value_reg  <= res_value_next;
                end
            end
        end
    end

    assign out_valid = res_valid_reg;
    assign target    = res_target_reg;
    assign value     = res_value_reg;

`ifndef SYNTHESIS
    // Brightness accumulator never passes the ceiling
    a_dec_cap: assert property (@(posedge clk) disable iff (!rst_n)
        dec_acc_reg <= ACC_W'(BRIGHT_MAX))
        else $error("brightness accumulator above ceiling");

    // Colour slot stays within the six rows
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("colour slot out of range");

    // A burst end always returns the decoder to mode wait
    a_burst_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && burst_end |=> phase_reg == PH_MODE)
        else $error("burst end did not return to mode wait");

    // Brightness results respect the ceiling
    a_bright_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == TGT_BRIGHT |-> value <= VALUE_W'(BRIGHT_MAX))
        else $error("brightness result above ceiling");

    // Only a closing byte can load a new result
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && emit |-> burst_end || phase_reg == PH_MODE)
        else $error("result produced without burst end");
`endif

endmodule

// ===== sim/sdcd_setting_checker.sv =====
// ----------------------------------------------------------------------------
// sdcd_setting_checker: result checker for the serial display command decoder
// Watches both channels, tracks the decode state of every accepted byte,
// queues the settings it should produce and compares each delivered one.
// ----------------------------------------------------------------------------
module sdcd_setting_checker
#(
    parameter int BRIGHT_MAX = sdcd_pkg::BRIGHT_MAX_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [sdcd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            burst_end,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [sdcd_pkg::TARGET_W-1:0]   target,
    input  logic [sdcd_pkg::VALUE_W-1:0]    value,
    output int                              failures,
    output int                              settings_pending
);
    import sdcd_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0]
    {
        WAIT_MODE,
        BRIGHT_DIGITS,
        COLOUR_ROW,
        COLOUR_HEX
    } decode_phase_t;

    typedef struct packed
    {
        logic [TARGET_W-1:0] target;
        logic [VALUE_W-1:0]  value;
    } setting_t;

    setting_t           settings_due[$];
    decode_phase_t      dec_phase    = WAIT_MODE;
    logic [SLOT_W-1:0]  row_slot     = SLOT_NONE;
    int                 bright_level = 0;
    logic [VALUE_W-1:0] colour_word  = '0;
    int                 fail_total   = 0;

    initial
    begin
        failures         = 0;
        settings_pending = 0;
    end

    // Hex digit value, -1 for anything else
    function automatic int hex_value(input logic [BYTE_W-1:0] b);
        if (b >= CH_ZERO && b <= CH_NINE)
            return int'(b) - int'(CH_ZERO);
        if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            return int'(b) - int'(CH_UPPER_A) + 10;
        if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            return int'(b) - int'(CH_LOWER_A) + 10;
        return -1;
    endfunction

    task automatic queue_setting(input logic [TARGET_W-1:0] tgt,
                                 input logic [VALUE_W-1:0] val);
        setting_t s;
        s.target = tgt;
        s.value  = val;
        settings_due.push_back(s);
    endtask

    // Advance the decode state by one accepted byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        int nibble;
        int level;
        nibble = hex_value(b);
        case (dec_phase)
            WAIT_MODE:
            begin
                if (b == CH_MODE_BRIGHT)
                begin
                    bright_level = 0;
                    if (last)
                        queue_setting(TGT_BRIGHT, '0);
                    else
                        dec_phase = BRIGHT_DIGITS;
                end
                else if (b == CH_MODE_COLOUR && !last)
                begin
                    dec_phase = COLOUR_ROW;
                end
            end
            BRIGHT_DIGITS:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    level = bright_level * 10 + int'(b) - int'(CH_ZERO);
                    bright_level = (level > BRIGHT_MAX) ? BRIGHT_MAX : level;
                end
                if (last)
                begin
                    queue_setting(TGT_BRIGHT, VALUE_W'(bright_level));
                    dec_phase = WAIT_MODE;
                end
            end
            COLOUR_ROW:
            begin
                if (b >= CH_ZERO && b <= CH_ROW_LAST)
                    row_slot = SLOT_W'(int'(b) - int'(CH_ZERO) + 1);
                else
                    row_slot = SLOT_NONE;
                colour_word = '0;
                if (last)
                begin
                    if (row_slot != SLOT_NONE)
                        queue_setting(TARGET_W'(row_slot), '0);
                    dec_phase = WAIT_MODE;
                end
                else
                begin
                    dec_phase = COLOUR_HEX;
                end
            end
            default:
            begin
                if (nibble >= 0)
                    colour_word = {colour_word[VALUE_W-5:0], 4'(nibble)};
                if (last)
                begin
                    if (row_slot != SLOT_NONE)
                        queue_setting(TARGET_W'(row_slot), colour_word);
                    dec_phase = WAIT_MODE;
                end
            end
        endcase
    endtask

    // Compare one delivered setting with the oldest queued one
    task automatic check_setting(input logic [TARGET_W-1:0] tgt,
                                 input logic [VALUE_W-1:0] val);
        setting_t want;
        if (settings_due.size() == 0)
        begin
            fail_total++;
            if (fail_total <= REPORT_MAX)
                $display("%0t: unexpected setting target=%0d value=%06h",
                         $realtime, tgt, val);
        end
        else
        begin
            want = settings_due.pop_front();
            if (want.target !== tgt || want.value !== val)
            begin
                fail_total++;
                if (fail_total <= REPORT_MAX)
                    $display({"%0t: setting mismatch: expected target=%0d value=%06h,",
                              " got target=%0d value=%06h"},
                             $realtime, want.target, want.value, tgt, val);
            end
        end
    endtask

    // Sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_phase    = WAIT_MODE;
            row_slot     = SLOT_NONE;
            bright_level = 0;
            colour_word  = '0;
            settings_due.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(rx_byte, burst_end);
            if (out_valid && out_ready)
                check_setting(target, value);
        end
        failures         <= fail_total;
        settings_pending <= settings_due.size();
    end

endmodule

// ===== sim/serial_display_command_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// serial_display_command_decoder_tb: testbench for the command decoder
// Sends directed brightness and colour commands, then random commands, some with
// stray bytes, mixed with noise bursts under several idle and stall patterns.
// ----------------------------------------------------------------------------
module serial_display_command_decoder_tb;
    import sdcd_pkg::*;

    localparam int BRIGHT_MAX   = BRIGHT_MAX_DEFAULT;
    localparam int RANDOM_BYTES = 1620;
    localparam int SEGMENTS     = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   rx_byte;
    logic                burst_end;
    logic                out_valid;
    logic                out_ready;
    logic [TARGET_W-1:0] target;
    logic [VALUE_W-1:0]  value;

    int chk_failures;
    int settings_pending;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_count   = 0;

    serial_display_command_decoder
    #(
        .BRIGHT_MAX (BRIGHT_MAX)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .burst_end (burst_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .target    (target),
        .value     (value)
    );

    sdcd_setting_checker
    #(
        .BRIGHT_MAX (BRIGHT_MAX)
    )
    i_setting_chk
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .burst_end        (burst_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .target           (target),
        .value            (value),
        .failures         (chk_failures),
        .settings_pending (settings_pending)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("serial_display_command_decoder_tb: FAIL");
            $finish;
        end
    end

    task automatic set_idling(input int pattern);
        case (pattern)
            0:       begin send_idle_pct = 0;  out_stall_pct <= 0;  end
            1:       begin send_idle_pct = 78; out_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  out_stall_pct <= 78; end
            default: begin send_idle_pct = 27; out_stall_pct <= 27; end
        endcase
    endtask

    // One byte transfer, with an optional idle gap in front
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        burst_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Text as one burst, the last character closing it
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [BYTE_W-1:0] random_hex_char();
        int pick;
        pick = $urandom_range(7);
        if (pick < 3)
            return CH_ZERO + BYTE_W'($urandom_range(9));
        if (pick < 5)
            return CH_UPPER_A + BYTE_W'($urandom_range(5));
        if (pick < 7)
            return CH_LOWER_A + BYTE_W'($urandom_range(5));
        return BYTE_W'($urandom_range(255));
    endfunction

    // 'b' plus a few digits, now and then a stray byte
    task automatic send_bright_cmd();
        int digits;
        logic [BYTE_W-1:0] b;
        digits = $urandom_range(4);
        send_byte(CH_MODE_BRIGHT, digits == 0);
        for (int i = 0; i < digits; i++)
        begin
            if ($urandom_range(7) == 0)
                b = BYTE_W'($urandom_range(255));
            else
                b = CH_ZERO + BYTE_W'($urandom_range(9));
            send_byte(b, i == digits - 1);
        end
    endtask

    // 'c', usually followed by a row byte (mostly valid) and up to eight hex characters
    task automatic send_colour_cmd();
        int digits;
        logic [BYTE_W-1:0] row;
        if ($urandom_range(19) == 0)
        begin
            send_byte(CH_MODE_COLOUR, 1'b1);
            return;
        end
        send_byte(CH_MODE_COLOUR, 1'b0);
        if ($urandom_range(9) < 8)
            row = CH_ZERO + BYTE_W'($urandom_range(5));
        else
            row = BYTE_W'($urandom_range(255));
        digits = $urandom_range(8);
        send_byte(row, digits == 0);
        for (int i = 0; i < digits; i++)
            send_byte(random_hex_char(), i == digits - 1);
    endtask

    // Random bytes; the burst always closes so the decoder resynchronizes
    task automatic send_noise();
        int count;
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++)
            send_byte(BYTE_W'($urandom_range(255)),
                      (i == count - 1) ? 1'b1 : 1'($urandom_range(1)));
    endtask

    initial
    begin
        int random_base;
        int pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        burst_end = 1'b0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: brightness with no digits, saturation, plain value,
        // burst closing on a non-digit
        send_byte(CH_MODE_BRIGHT, 1'b1);
        send_byte(CH_MODE_BRIGHT, 1'b0);
        send_text("9x99");
        send_byte(CH_MODE_BRIGHT, 1'b0);
        send_text("50");
        send_byte(CH_MODE_BRIGHT, 1'b0);
        send_text("7z");
        // Colour: mode closing the burst, row closing the burst, long hex
        send_byte(CH_MODE_COLOUR, 1'b1);
        send_byte(CH_MODE_COLOUR, 1'b0);
        send_text("5");
        send_byte(CH_MODE_COLOUR, 1'b0);
        send_text("0Ff00aA12");
        // Invalid row, then unknown mode bytes, then non-hex closing byte
        send_byte(CH_MODE_COLOUR, 1'b0);
        send_text("9ab");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(CH_MODE_COLOUR, 1'b0);
        send_text("3g");

        // Random commands, cycling through the idle patterns
        random_base = bytes_sent;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            set_idling(seg % 4);
            while (bytes_sent < random_base + (seg + 1) * (RANDOM_BYTES / SEGMENTS))
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    send_bright_cmd();
                else if (pick < 80)
                    send_colour_cmd();
                else
                    send_noise();
            end
        end
        in_valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (settings_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (settings_pending != 0)
            $display("%0d expected settings never arrived", settings_pending);
        if (chk_failures == 0 && settings_pending == 0)
            $display("serial_display_command_decoder_tb: PASS");
        else
            $display("serial_display_command_decoder_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdcd_pkg.sv
hw/rtl/serial_display_command_decoder.sv
sim/sdcd_setting_checker.sv
sim/serial_display_command_decoder_tb.sv
